[hw/rtl/lesum_pkg.sv]
// ----------------------------------------------------------------------------
// Local extrema sum package
// Shared constants and register codes for the 3x3 local extrema summer.
// ----------------------------------------------------------------------------
package lesum_pkg;

    // Default sizing of the frame store and of the sample word.
    localparam int DEF_MAX_COLS    = 512;
    localparam int DEF_MAX_ROWS    = 512;
    localparam int DEF_SAMPLE_BITS = 16;

    // Width of the frame size registers and of the running total.
    localparam int CFG_BITS = 10;
    localparam int SUM_BITS = 36;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } cfg_reg_t;

endpackage

[hw/rtl/local_extrema_sum_3x3_unit.sv]
// ----------------------------------------------------------------------------
// Local extrema sum, 3x3 window
// Sums the strict local maxima and minima of a raster frame of samples.
// ----------------------------------------------------------------------------
// The block takes one sample per cycle in raster order and, after the last
// sample of a frame, emits one transfer carrying the sum of every sample that
// is strictly above, or strictly below, all of its in-frame 3x3 neighbours.
// Inside, each sample first shifts the window and updates the two line
// stores; the completed centres are then judged and accumulated.
// The line stores each have one write and one read port and are read one
// column ahead, so a new sample is taken in every cycle; input is held only
// when a finished total is waiting and the next total is ready behind it.
// No clearing pass is needed after reset. Frame size is set through the
// write port and should only be changed between frames.
module local_extrema_sum_3x3_unit #(
    parameter int MAX_COLS    = lesum_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = lesum_pkg::DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = lesum_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  lesum_pkg::cfg_reg_t                   cfg_index,
    input  logic [lesum_pkg::CFG_BITS-1:0]        cfg_wdata,
    // Sample stream.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample
    // Result stream.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((lesum_pkg::SUM_BITS+7)/8)*8-1:0] m_tdata // extrema_sum
);

    localparam int SUM_BITS = lesum_pkg::SUM_BITS;
    localparam int CFG_BITS = lesum_pkg::CFG_BITS;
    localparam int OUT_W    = ((SUM_BITS + 7) / 8) * 8;
    localparam int CI_W     = $clog2(MAX_COLS);
    localparam int RC_W     = $clog2(MAX_ROWS + 1);
    localparam int CC_W     = $clog2(MAX_COLS + 1);
    localparam int MX_W     = (RC_W > CC_W) ? RC_W : CC_W;
    localparam int CMP_W    = ((CFG_BITS > MX_W) ? CFG_BITS : MX_W) + 1;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef smp_t win_t [3][3];

    typedef struct packed {
        logic valid;
        logic r1;
        logic r2;
        logic c1;
        logic c2;
        logic row_end;
        logic last_row;
    } stage_t;

    // Contribution of one centre of the window; rows and columns with a
    // clear bit lie outside the frame.
    function automatic logic signed [SUM_BITS-1:0] judge(
        input win_t w, input int cr, input int cc,
        input logic [2:0] rv, input logic [2:0] cv
    );
        logic is_max;
        logic is_min;
        logic signed [SUM_BITS-1:0] ext;
        is_max = 1'b1;
        is_min = 1'b1;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r - cr <= 1) && (cr - r <= 1) && (c - cc <= 1) && (cc - c <= 1)
                    && !(r == cr && c == cc) && rv[r] && cv[c]) begin
                    if (w[r][c] >= w[cr][cc]) is_max = 1'b0;
                    if (w[r][c] <= w[cr][cc]) is_min = 1'b0;
                end
            end
        end
        ext = {{(SUM_BITS-SAMPLE_BITS){w[cr][cc][SAMPLE_BITS-1]}}, w[cr][cc]};
        return (is_max ? ext : '0) + (is_min ? ext : '0);
    endfunction

    logic [CFG_BITS-1:0] rows_cfg_reg;
    logic [CFG_BITS-1:0] cols_cfg_reg;
    logic [CI_W-1:0]     col_reg, col_next;
    logic [RC_W-1:0]     row_reg, row_next;
    win_t                win_reg, win_next;
    stage_t              st_reg, st_next;
    logic [SUM_BITS-1:0] acc_reg;
    logic                m_valid_reg;
    logic [SUM_BITS-1:0] m_data_reg;

    smp_t above_mem [MAX_COLS];
    smp_t two_mem   [MAX_COLS];
    smp_t above_q_reg, two_q_reg;
    logic byp_reg;
    smp_t byp_s_reg, byp_above_reg;

    logic                accept, advance, row_end, last_row;
    logic [CMP_W-1:0]    rows_eff, cols_eff, rows_raw, cols_raw;
    logic [CI_W-1:0]     rd_addr;
    smp_t                sample, above_eff, two_eff;
    logic signed [SUM_BITS-1:0] add;
    logic [SUM_BITS-1:0] sum;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CFG_BITS'(1);
            cols_cfg_reg <= CFG_BITS'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                lesum_pkg::REG_FRAME_ROWS: rows_cfg_reg <= cfg_wdata;
                lesum_pkg::REG_FRAME_COLS: cols_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp frame size to 1..maximum.
    always_comb begin
        rows_raw = CMP_W'(rows_cfg_reg);
        cols_raw = CMP_W'(cols_cfg_reg);
        if (rows_raw == '0) rows_eff = CMP_W'(1);
        else if (rows_raw > CMP_W'(MAX_ROWS)) rows_eff = CMP_W'(MAX_ROWS);
        else rows_eff = rows_raw;
        if (cols_raw == '0) cols_eff = CMP_W'(1);
        else if (cols_raw > CMP_W'(MAX_COLS)) cols_eff = CMP_W'(MAX_COLS);
        else cols_eff = cols_raw;
    end

    // Handshake: input stalls only when a total is waiting behind a total.
    assign advance  = !st_reg.valid || !st_reg.last_row || !st_reg.row_end
                      || !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];

    // Position of the sample and the window shift.
    always_comb begin
        row_end  = (CMP_W'(col_reg) + CMP_W'(1)) >= cols_eff;
        last_row = (CMP_W'(row_reg) + CMP_W'(1)) >= rows_eff;
        above_eff = byp_reg ? byp_s_reg : above_q_reg;
        two_eff   = byp_reg ? byp_above_reg : two_q_reg;
        col_next = col_reg;
        row_next = row_reg;
        win_next = win_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RC_W'(1);
            end else begin
                col_next = col_reg + CI_W'(1);
            end
            for (int i = 0; i < 3; i++) begin
                win_next[i][0] = win_reg[i][1];
                win_next[i][1] = win_reg[i][2];
            end
            win_next[0][2] = two_eff;
            win_next[1][2] = above_eff;
            win_next[2][2] = sample;
        end
        st_next.valid    = accept;
        st_next.r1       = row_reg >= RC_W'(1);
        st_next.r2       = row_reg >= RC_W'(2);
        st_next.c1       = col_reg >= CI_W'(1);
        st_next.c2       = col_reg >= CI_W'(2);
        st_next.row_end  = row_end;
        st_next.last_row = last_row;
        rd_addr = col_next;
    end

    // Line stores, read one column ahead; a same-column write is bypassed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            above_mem[col_reg] <= sample;
            two_mem[col_reg]   <= above_eff;
        end
        above_q_reg <= above_mem[rd_addr];
        two_q_reg   <= two_mem[rd_addr];
        byp_s_reg     <= sample;
        byp_above_reg <= above_eff;
    end

    // Judge the completed centres and form the increment.
    always_comb begin
        logic [2:0] rv, cv;
        rv  = {1'b1, st_reg.r1, st_reg.r2};
        cv  = {1'b1, st_reg.c1, st_reg.c2};
        add = '0;
        if (st_reg.r1 && st_reg.c1)            add = add + judge(win_reg, 1, 1, rv, cv);
        if (st_reg.r1 && st_reg.row_end)       add = add + judge(win_reg, 1, 2, rv, cv);
        if (st_reg.last_row && st_reg.c1)      add = add + judge(win_reg, 2, 1, rv, cv);
        if (st_reg.last_row && st_reg.row_end) add = add + judge(win_reg, 2, 2, rv, cv);
        sum = acc_reg + add;
    end

    // Control, window and accumulator registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            st_reg      <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
            byp_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            win_reg <= win_next;
            byp_reg <= accept && (rd_addr == col_reg);
            // A new total takes the output register; otherwise it empties on a transfer.
            if (advance && st_reg.valid && st_reg.row_end && st_reg.last_row) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                st_reg <= st_next;
                if (st_reg.valid) begin
                    if (st_reg.row_end && st_reg.last_row) begin
                        acc_reg    <= '0;
                        m_data_reg <= sum;
                    end else begin
                        acc_reg <= sum;
                    end
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

endmodule
